[src/accel_tilt_pitch_roll_macros.svh]
// Assertion macros used by the tilt block controller.
`ifndef ACCEL_TILT_PITCH_ROLL_MACROS_SVH
`define ACCEL_TILT_PITCH_ROLL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define APR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define APR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/apr_pkg.sv]
// Package: constants, state and control types of the tilt block.
package apr_pkg;

	localparam int SAMPLE_BITS_DEF    = 14;
	localparam int COEF_FRAC_BITS_DEF = 10;

	localparam int SW_WIDTH        = 11;
	localparam int DZ_WIDTH        = 13;
	localparam int CFG_DATA_WIDTH  = 13;
	localparam int CFG_INDEX_WIDTH = 2;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SMOOTHING = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEAD_ZONE = 2'd1;

	localparam logic [SW_WIDTH-1:0] SMOOTHING_RESET = 11'd983;
	localparam logic [DZ_WIDTH-1:0] DEAD_ZONE_RESET = 13'd41;

	// arctangent polynomial, Q24 radians, ratio in Q1.16
	localparam int T_BITS   = 17;
	localparam int DIV_STEPS = 17;
	localparam logic [23:0] ATAN_A  = 24'd13176795;
	localparam logic [22:0] ATAN_B  = 23'd4105385;
	localparam logic [20:0] ATAN_C  = 21'd1112329;
	localparam logic [21:0] DEG_Q16 = 22'd3755047;
	localparam logic signed [15:0] NINETY_Q8 = 16'sd23040;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILT,
		S_SQ,
		S_SUM,
		S_ROOT,
		S_ALOAD,
		S_DIV,
		S_P1,
		S_P2,
		S_P3,
		S_P4,
		S_DONE
	} apr_state_t;

	typedef struct packed {
		logic in_ready;
		logic filt;
		logic sq;
		logic sum;
		logic root_step;
		logic at_load;
		logic at_roll;
		logic div_step;
		logic p1;
		logic p2;
		logic p3;
		logic fin;
		logic out_load;
	} apr_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} apr_status_t;

endpackage

[src/apr_if.sv]
// Stream interfaces: raw sample request in, angle pair out.
interface apr_sample_if;
	logic       valid;
	logic       ready;
	logic [7:0] x_high;
	logic [7:0] x_low;
	logic [7:0] y_high;
	logic [7:0] y_low;
	logic [7:0] z_high;
	logic [7:0] z_low;
	modport source(output valid, x_high, x_low, y_high, y_low, z_high, z_low, input ready);
	modport sink(input valid, x_high, x_low, y_high, y_low, z_high, z_low, output ready);
endinterface

interface apr_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pitch_deg;
	logic signed [15:0] roll_deg;
	modport source(output valid, pitch_deg, roll_deg, input ready);
	modport sink(input valid, pitch_deg, roll_deg, output ready);
endinterface

[src/apr_datapath.sv]
// Datapath: filter lanes, squares, root, divider, polynomial, result register.
module apr_datapath #(
	parameter int SAMPLE_BITS    = apr_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = apr_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [apr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [apr_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	input  apr_pkg::apr_cmd_t                    cmd,
	output apr_pkg::apr_status_t                 status,
	apr_sample_if.sink                           sample,
	apr_result_if.source                         result
);
	import apr_pkg::*;

	localparam int F   = COEF_FRAC_BITS;
	localparam int SW  = SAMPLE_BITS + COEF_FRAC_BITS;
	localparam int WB  = (F + 1 > SW_WIDTH) ? F + 1 : SW_WIDTH;
	localparam int PW  = WB + 1 + SW;
	localparam int AW  = PW + 1;
	localparam int MW  = SW;
	localparam int RW  = MW + 1;
	localparam int DZW = DZ_WIDTH + F;
	localparam int CW  = (MW > DZW) ? MW : DZW;
	localparam int SQW = (2 * MW + 1 > 2 * DZW) ? 2 * MW + 1 : 2 * DZW;
	localparam int NW  = RW + T_BITS;

	localparam logic [WB-1:0] ONE = WB'(1) << F;
	localparam logic signed [AW-1:0] HALF = AW'(1) << (F - 1);

	function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
		mag = v[SW-1] ? MW'(~v + 1'b1) : MW'(v);
	endfunction

	// configuration
	logic [SW_WIDTH-1:0] sw_q;
	logic [DZ_WIDTH-1:0] dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= SMOOTHING_RESET;
			dz_q <= DEAD_ZONE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SMOOTHING: sw_q <= cfg_data[SW_WIDTH-1:0];
				CFG_DEAD_ZONE: dz_q <= cfg_data[DZ_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// sample capture
	logic signed [SAMPLE_BITS-1:0] raw_q [3];
	logic                          load;

	assign sample.ready    = cmd.in_ready;
	assign load            = sample.valid & sample.ready;
	assign status.in_valid = sample.valid;

	always_ff @(posedge clk) begin
		if (load) begin
			raw_q[0] <= {sample.x_high, sample.x_low[7 -: (SAMPLE_BITS - 8)]};
			raw_q[1] <= {sample.y_high, sample.y_low[7 -: (SAMPLE_BITS - 8)]};
			raw_q[2] <= {sample.z_high, sample.z_low[7 -: (SAMPLE_BITS - 8)]};
		end
	end

	// low-pass filter, three lanes
	logic [WB-1:0]        w_ext, w_cl;
	logic signed [WB:0]   w_s, omw_s;
	logic signed [SW-1:0] sm_q [3];
	logic signed [SW-1:0] sm_next [3];

	assign w_ext = WB'(sw_q);
	assign w_cl  = (w_ext > ONE) ? ONE : w_ext;
	assign w_s   = {1'b0, w_cl};
	assign omw_s = {1'b0, ONE - w_cl};

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic signed [PW-1:0] prod_old, prod_new;
		logic signed [AW-1:0] acc, acc_sh;
		always_comb begin
			prod_old = w_s * sm_q[i];
			prod_new = omw_s * $signed({raw_q[i], {F{1'b0}}});
			acc      = AW'(prod_old) + AW'(prod_new) + HALF;
			acc_sh   = acc >>> F;
			sm_next[i] = acc_sh[SW-1:0];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sm_q[i] <= '0;
			end else if (cmd.filt) begin
				sm_q[i] <= sm_next[i];
			end
		end
	end

	// squares and dead zones
	logic [MW-1:0]    xmag, ymag, zmag;
	logic [DZW-1:0]   dz_full;
	logic [2*MW-1:0]  ysq_q, zsq_q;
	logic [2*DZW-1:0] dzsq_q;
	logic [SQW-1:0]   sum;
	logic             pdead_q, zdead;

	assign xmag    = mag(sm_q[0]);
	assign ymag    = mag(sm_q[1]);
	assign zmag    = mag(sm_q[2]);
	assign dz_full = {dz_q, {F{1'b0}}};
	assign zdead   = CW'(zmag) < CW'(dz_full);
	assign sum     = SQW'(ysq_q) + SQW'(zsq_q);

	always_ff @(posedge clk) begin
		if (cmd.sq) begin
			ysq_q  <= ymag * ymag;
			zsq_q  <= zmag * zmag;
			dzsq_q <= dz_full * dz_full;
		end
		if (cmd.sum) begin
			pdead_q <= sum < SQW'(dzsq_q);
		end
	end

	// integer square root, two radicand bits a step
	logic [2*RW-1:0] rad_q;
	logic [RW-1:0]   root_q;
	logic [RW:0]     rem_q;
	logic [RW+2:0]   cand, trial;

	assign cand  = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial = (RW + 3)'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			rad_q  <= (2 * RW)'(sum);
			root_q <= '0;
			rem_q  <= '0;
		end else if (cmd.root_step) begin
			rad_q <= rad_q << 2;
			if (cand >= trial) begin
				rem_q  <= (RW + 1)'(cand - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= cand[RW:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	// arctangent: operand set-up and ratio divider
	logic [RW-1:0]     an, ad, lo, hi, hi_q, drem_q;
	logic [NW-1:0]     num;
	logic [T_BITS-1:0] nlo_q, quo_q;
	logic              fold, fold_q, zero_q, neg_q;
	logic [RW:0]       dsh;

	always_comb begin
		an   = cmd.at_roll ? RW'(ymag) : RW'(xmag);
		ad   = cmd.at_roll ? RW'(zmag) : root_q;
		fold = an > ad;
		lo   = fold ? ad : an;
		hi   = fold ? an : ad;
		num  = {lo, {(T_BITS - 1){1'b0}}} + NW'(hi >> 1);
	end

	assign dsh = {drem_q, nlo_q[T_BITS-1]};

	always_ff @(posedge clk) begin
		if (cmd.at_load) begin
			hi_q   <= hi;
			drem_q <= num[NW-1 -: RW];
			nlo_q  <= num[T_BITS-1:0];
			fold_q <= fold;
			zero_q <= (cmd.at_roll ? zdead : pdead_q) || (hi == '0);
			neg_q  <= cmd.at_roll ? (sm_q[1][SW-1] != sm_q[2][SW-1]) : sm_q[0][SW-1];
		end else if (cmd.div_step) begin
			nlo_q <= nlo_q << 1;
			if (dsh >= {1'b0, hi_q}) begin
				drem_q <= RW'(dsh - {1'b0, hi_q});
				quo_q  <= {quo_q[T_BITS-2:0], 1'b1};
			end else begin
				drem_q <= dsh[RW-1:0];
				quo_q  <= {quo_q[T_BITS-2:0], 1'b0};
			end
		end
	end

	// polynomial and degree scaling
	logic [40:0]       at_q;
	logic [37:0]       ct_q;
	logic [31:0]       tu_q;
	logic [T_BITS-1:0] u;
	logic [33:0]       tu_full;
	logic [23:0]       coef;
	logic [24:0]       pa_q;
	logic [55:0]       big_q;
	logic [25:0]       p;
	logic [47:0]       qp_q, qsum;
	logic signed [15:0] qv, ang, aval, sval;
	logic signed [15:0] pitch_q, roll_q;

	assign u       = T_BITS'(1 << 16) - quo_q;
	assign tu_full = quo_q * u;
	assign coef    = 24'(ATAN_B) + 24'(ct_q >> 16);
	assign p       = 26'(pa_q) + 26'(big_q >> 32);
	assign qsum    = qp_q + (48'd1 << 31);
	assign qv      = qsum[47:32];
	assign ang     = fold_q ? NINETY_Q8 - qv : qv;
	assign aval    = zero_q ? 16'sd0 : ang;
	assign sval    = neg_q ? -aval : aval;

	always_ff @(posedge clk) begin
		if (cmd.p1) begin
			at_q <= ATAN_A * quo_q;
			ct_q <= ATAN_C * quo_q;
			tu_q <= tu_full[31:0];
		end
		if (cmd.p2) begin
			pa_q  <= at_q[40:16];
			big_q <= tu_q * coef;
		end
		if (cmd.p3) begin
			qp_q <= p * DEG_Q16;
		end
		if (cmd.fin) begin
			if (cmd.at_roll) begin
				roll_q <= sval;
			end else begin
				pitch_q <= -sval;
			end
		end
	end

	// result register
	logic               out_valid_q;
	logic signed [15:0] out_pitch_q, out_roll_q;

	assign status.out_free = !out_valid_q || result.ready;
	assign result.valid     = out_valid_q;
	assign result.pitch_deg = out_pitch_q;
	assign result.roll_deg  = out_roll_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pitch_q <= pitch_q;
			out_roll_q  <= roll_q;
		end
	end

endmodule

[src/apr_ctrl.sv]
// Controller: sequences filter, root, divider and polynomial steps.
`include "accel_tilt_pitch_roll_macros.svh"

module apr_ctrl #(
	parameter int SAMPLE_BITS    = apr_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = apr_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  apr_pkg::apr_status_t status,
	output apr_pkg::apr_cmd_t    cmd
);
	import apr_pkg::*;

	localparam int RW   = SAMPLE_BITS + COEF_FRAC_BITS + 1;
	localparam int MAXN = (RW > DIV_STEPS) ? RW : DIV_STEPS;
	localparam int CNTW = $clog2(MAXN);
	localparam logic [CNTW-1:0] ROOT_LAST = CNTW'(RW - 1);
	localparam logic [CNTW-1:0] DIV_LAST  = CNTW'(DIV_STEPS - 1);

	apr_state_t      state_q, state_d;
	logic [CNTW-1:0] cnt_q;
	logic            roll_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (status.in_valid) state_d = S_FILT;
			S_FILT:  state_d = S_SQ;
			S_SQ:    state_d = S_SUM;
			S_SUM:   state_d = S_ROOT;
			S_ROOT:  if (cnt_q == ROOT_LAST) state_d = S_ALOAD;
			S_ALOAD: state_d = S_DIV;
			S_DIV:   if (cnt_q == DIV_LAST) state_d = S_P1;
			S_P1:    state_d = S_P2;
			S_P2:    state_d = S_P3;
			S_P3:    state_d = S_P4;
			S_P4:    state_d = roll_q ? S_DONE : S_ALOAD;
			S_DONE:  if (status.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.at_roll = roll_q;
		case (state_q)
			S_IDLE:  cmd.in_ready  = 1'b1;
			S_FILT:  cmd.filt      = 1'b1;
			S_SQ:    cmd.sq        = 1'b1;
			S_SUM:   cmd.sum       = 1'b1;
			S_ROOT:  cmd.root_step = 1'b1;
			S_ALOAD: cmd.at_load   = 1'b1;
			S_DIV:   cmd.div_step  = 1'b1;
			S_P1:    cmd.p1        = 1'b1;
			S_P2:    cmd.p2        = 1'b1;
			S_P3:    cmd.p3        = 1'b1;
			S_P4:    cmd.fin       = 1'b1;
			S_DONE:  cmd.out_load  = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			roll_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_SUM: begin
					cnt_q  <= '0;
					roll_q <= 1'b0;
				end
				S_ALOAD: cnt_q <= '0;
				S_ROOT, S_DIV: cnt_q <= cnt_q + 1'b1;
				S_P4: roll_q <= 1'b1;
				default: ;
			endcase
		end
	end

	`APR_ASSERT_NXT(a_accept_starts, state_q == S_IDLE && status.in_valid, state_q == S_FILT)
	`APR_ASSERT_IMP(a_load_when_free, cmd.out_load, status.out_free)
	`APR_ASSERT_NXT(a_root_ends, state_q == S_ROOT && cnt_q == ROOT_LAST, state_q == S_ALOAD)
	`APR_ASSERT_IMP(a_done_after_roll, state_q == S_DONE, roll_q)

endmodule

[src/accel_tilt_pitch_roll.sv]
// Requests are handled one at a time: a new one is taken only after the last result enters the output
// register. The root takes one result bit a cycle and the shared ratio divider serves pitch, then roll.
// A new request is taken while the previous result still waits in the output register;
// the last step stalls for as long as that register stays full.
// Reset (arst_n low, asynchronous) clears filter state, control and output valid, loads defaults.
module accel_tilt_pitch_roll #(
	parameter int SAMPLE_BITS    = apr_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = apr_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [apr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [apr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	apr_sample_if.sink                          sample,
	apr_result_if.source                        result
);
	import apr_pkg::*;

	apr_cmd_t    cmd;
	apr_status_t status;

	apr_ctrl #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	apr_datapath #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.sample    (sample),
		.result    (result)
	);

endmodule

[bench/tb.sv]
// Self-checking bench for the accelerometer tilt block: random and directed samples, angle check.
`timescale 1ns / 1ps

module tb;
	import apr_pkg::*;

	typedef struct {
		logic [7:0] b[6];
	} raw_sample_t;

	typedef struct {
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
	} angle_pair_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_data;

	apr_sample_if sample ();
	apr_result_if result ();

	accel_tilt_pitch_roll uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample.sink),
		.result(result.source)
	);

	localparam int WATCHDOG_LIMIT = 5000;

	raw_sample_t pending_samples[$];
	angle_pair_t expected_angles[$];
	longint filt_axis[3];
	int unsigned weight_reg;
	int unsigned dead_zone_reg;
	int errors;
	bit quiet;
	bit hold_sender;
	bit in_taken;
	int src_gap;
	int snk_gap;
	int idle_cycles;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint atan_q8(longint unsigned an, longint unsigned ad, bit neg);
		bit fold;
		longint unsigned lo, hi, t, u, p, q;
		longint ang;
		fold = an > ad;
		lo = fold ? ad : an;
		hi = fold ? an : ad;
		if (hi == 0)
			return 0;
		t = ((lo << 16) + (hi >> 1)) / hi;
		u = 65536 - t;
		p = ((64'(ATAN_A) * t) >> 16)
			+ (((t * u) * (64'(ATAN_B) + ((64'(ATAN_C) * t) >> 16))) >> 32);
		q = (p * 64'(DEG_Q16) + (64'd1 << 31)) >> 32;
		ang = fold ? 64'sd23040 - longint'(q) : longint'(q);
		return neg ? -ang : ang;
	endfunction

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	// advance the filters and work out the angle pair for one request
	function automatic angle_pair_t tilt_of(raw_sample_t s);
		angle_pair_t r;
		longint w, a, acc, x, y, z;
		longint unsigned dz, sum;
		logic [13:0] raw;
		w = (weight_reg > 1024) ? 1024 : weight_reg;
		dz = longint'(dead_zone_reg) << 10;
		for (int i = 0; i < 3; i++) begin
			raw = {s.b[2*i], s.b[2*i+1][7:2]};
			a = longint'($signed(raw));
			acc = w * filt_axis[i] + (1024 - w) * (a * 1024) + 512;
			filt_axis[i] = acc >>> 10;
		end
		x = filt_axis[0];
		y = filt_axis[1];
		z = filt_axis[2];
		sum = magn(y) * magn(y) + magn(z) * magn(z);
		r.pitch = (sum < dz * dz) ? 16'sd0 : 16'(-atan_q8(magn(x), int_sqrt(sum), x < 0));
		r.roll = (magn(z) < dz) ? 16'sd0 : 16'(atan_q8(magn(y), magn(z), (y < 0) != (z < 0)));
		return r;
	endfunction

	// sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (sample.valid && !in_taken) begin
				// hold the request until it is taken
			end else if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				sample.valid <= 1'b0;
			end else if (pending_samples.size() > 0 && !hold_sender) begin
				raw_sample_t s;
				s = pending_samples.pop_front();
				sample.x_high <= s.b[0];
				sample.x_low <= s.b[1];
				sample.y_high <= s.b[2];
				sample.y_low <= s.b[3];
				sample.z_high <= s.b[4];
				sample.z_low <= s.b[5];
				sample.valid <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					src_gap <= $urandom_range(1, 3);
			end else begin
				sample.valid <= 1'b0;
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (quiet) begin
				result.ready <= 1'b1;
			end else if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				result.ready <= 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				snk_gap <= $urandom_range(0, 2);
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= sample.valid && sample.ready;
			if (sample.valid && sample.ready) begin
				raw_sample_t s;
				s.b[0] = sample.x_high;
				s.b[1] = sample.x_low;
				s.b[2] = sample.y_high;
				s.b[3] = sample.y_low;
				s.b[4] = sample.z_high;
				s.b[5] = sample.z_low;
				expected_angles.push_back(tilt_of(s));
			end
			if (result.valid && result.ready) begin
				angle_pair_t e;
				if (expected_angles.size() == 0) begin
					$display("%0t: unexpected result pitch %0d roll %0d", $time,
						result.pitch_deg, result.roll_deg);
					errors++;
				end else begin
					e = expected_angles.pop_front();
					if (result.pitch_deg !== e.pitch) begin
						$display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
							result.pitch_deg);
						errors++;
					end
					if (result.roll_deg !== e.roll) begin
						$display("%0t: roll expected %0d actual %0d", $time, e.roll,
							result.roll_deg);
						errors++;
					end
				end
			end
			if ((sample.valid && sample.ready) || (result.valid && result.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_WIDTH-1:0];
		if (idx == CFG_SMOOTHING)
			weight_reg = val & 32'h7FF;
		else if (idx == CFG_DEAD_ZONE)
			dead_zone_reg = val & 32'h1FFF;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_bytes(input logic [7:0] xh, xl, yh, yl, zh, zl);
		raw_sample_t s;
		s.b[0] = xh;
		s.b[1] = xl;
		s.b[2] = yh;
		s.b[3] = yl;
		s.b[4] = zh;
		s.b[5] = zl;
		pending_samples.push_back(s);
	endtask

	task automatic push_random(input int n);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 3))
				0: push_bytes($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				// near zero g: exercises the dead zone
				1: push_bytes({{6{$urandom_range(0, 1) == 1}}, 2'($urandom)}, $urandom,
					{{6{$urandom_range(0, 1) == 1}}, 2'($urandom)}, $urandom,
					{{6{$urandom_range(0, 1) == 1}}, 2'($urandom)}, $urandom);
				// one axis dominant, as when lying still
				2: push_bytes($urandom_range(0, 15), $urandom, $urandom_range(0, 15),
					$urandom, 8'h40, $urandom);
				default: push_bytes($urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 255), $urandom_range(0, 3));
			endcase
		end
	endtask

	// wait until everything sent has come back
	task automatic drain;
		wait (pending_samples.size() == 0 && expected_angles.size() == 0 && !sample.valid);
		repeat (90) @(negedge clk);
	endtask

	initial begin
		errors = 0;
		quiet = 1'b0;
		hold_sender = 1'b0;
		in_taken = 1'b0;
		src_gap = 0;
		snk_gap = 0;
		idle_cycles = 0;
		filt_axis = '{0, 0, 0};
		weight_reg = SMOOTHING_RESET;
		dead_zone_reg = DEAD_ZONE_RESET;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample.valid = 1'b0;
		sample.x_high = '0;
		sample.x_low = '0;
		sample.y_high = '0;
		sample.y_low = '0;
		sample.z_high = '0;
		sample.z_low = '0;
		result.ready = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// reset defaults
		push_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00);
		push_bytes(8'h7F, 8'hFC, 8'h80, 8'h00, 8'h7F, 8'hFF);
		push_bytes(8'h80, 8'h03, 8'h7F, 8'hFC, 8'h80, 8'h00);
		drain();

		// no smoothing, no dead zone: zero denominators
		write_reg(CFG_SMOOTHING, 0);
		write_reg(CFG_DEAD_ZONE, 0);
		push_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_bytes(8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_bytes(8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_bytes(8'h00, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00);
		push_bytes(8'h00, 8'h00, 8'hE0, 8'h00, 8'h00, 8'h00);
		push_bytes(8'h10, 8'h00, 8'h10, 8'h00, 8'hF0, 8'h00);
		push_bytes(8'hF0, 8'h00, 8'h30, 8'h00, 8'h08, 8'h00);
		push_bytes(8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00);
		push_bytes(8'h7F, 8'hFF, 8'h7F, 8'hFF, 8'h7F, 8'hFF);
		push_bytes(8'hFF, 8'hFC, 8'h00, 8'h04, 8'hFF, 8'hFC);
		push_random(120);
		drain();

		// weight above one holds the filter; widest dead zone; unused indexes
		write_reg(CFG_SMOOTHING, 2047);
		write_reg(CFG_DEAD_ZONE, 8191);
		write_reg(CFG_INDEX_WIDTH'(2), 13'h1555);
		write_reg(CFG_INDEX_WIDTH'(3), 13'h0AAA);
		push_bytes(8'h7F, 8'hFC, 8'h7F, 8'hFC, 8'h7F, 8'hFC);
		push_random(20);
		drain();
		write_reg(CFG_SMOOTHING, 1025);
		write_reg(CFG_DEAD_ZONE, 1);
		push_random(20);
		drain();

		write_reg(CFG_SMOOTHING, 1024);
		write_reg(CFG_DEAD_ZONE, 41);
		push_random(20);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_SMOOTHING, $urandom_range(0, 1024));
			write_reg(CFG_DEAD_ZONE, $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
				: $urandom_range(0, 200));
			push_random(60);
			drain();
		end

		// last stretch at full rate
		write_reg(CFG_SMOOTHING, 512);
		write_reg(CFG_DEAD_ZONE, 5);
		quiet = 1'b1;
		push_random(80);
		drain();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

[accel_tilt_pitch_roll.f]
+incdir+src
src/apr_pkg.sv
src/apr_if.sv
src/apr_datapath.sv
src/apr_ctrl.sv
src/accel_tilt_pitch_roll.sv
bench/tb.sv
